// ===== hw/rtl/servo_pulse_sequencer_unit_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef SERVO_PULSE_SEQUENCER_UNIT_MACROS_SVH
`define SERVO_PULSE_SEQUENCER_UNIT_MACROS_SVH

// Checked only while out of reset.
`define SVPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SVPS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/svps_pkg.sv =====
package svps_pkg;

	localparam int PIN_W   = 12;
	localparam int SLOT_W  = 4;
	localparam int WIDTH_W = 12;
	localparam int TICK_W  = 13;
	localparam int DATA_W  = 16;
	localparam int TRIM_N  = 12;

	localparam logic [TICK_W-1:0] SLOT_TICKS_RESET = 13'd5000;
	localparam logic ACTIVE_LEVEL_RESET = 1'b1;

	typedef enum logic {
		CFG_SLOT_TICKS   = 1'b0,
		CFG_ACTIVE_LEVEL = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		KIND_TICK  = 1'b0,
		KIND_WRITE = 1'b1
	} item_kind_t;

	localparam logic [WIDTH_W-1:0] TRIM_DEFAULT [TRIM_N] = '{
		12'd1650, 12'd950, 12'd1310, 12'd1500, 12'd1975, 12'd1790,
		12'd1510, 12'd1170, 12'd1225, 12'd1560, 12'd2000, 12'd1770
	};

	typedef struct packed {
		logic               en;
		logic [SLOT_W-1:0]  addr;
		logic [WIDTH_W-1:0] data;
	} tbl_wr_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [PIN_W-1:0]  pins;
	} result_t;

endpackage

// ===== hw/rtl/svps_table.sv =====
module svps_table #(
	parameter int CHANNELS = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  svps_pkg::tbl_wr_t           wr,
	input  logic [svps_pkg::SLOT_W-1:0] rd_idx,
	output logic [svps_pkg::WIDTH_W-1:0] rd_data
);
	import svps_pkg::*;

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DEPTH = 2 ** IDX_W;

	logic [WIDTH_W-1:0] width_q [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_entry
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				width_q[i] <= (i < TRIM_N && i < CHANNELS) ? TRIM_DEFAULT[i % TRIM_N] : '0;
			end else if (wr.en && wr.addr[IDX_W-1:0] == IDX_W'(i)) begin
				width_q[i] <= wr.data;
			end
		end
	end

	assign rd_data = width_q[rd_idx[IDX_W-1:0]];

endmodule

// ===== hw/rtl/svps_seq.sv =====
module svps_seq #(
	parameter int CHANNELS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         tick,
	input  logic [svps_pkg::TICK_W-1:0]  slot_ticks,
	input  logic                         active_level,
	input  logic [svps_pkg::WIDTH_W-1:0] rd_data,
	output logic [svps_pkg::SLOT_W-1:0]  rd_idx,
	output svps_pkg::result_t            res
);
	import svps_pkg::*;

	logic [SLOT_W-1:0] slot_q;
	logic              phase_high_q;
	logic [TICK_W-1:0] ticks_left_q;
	logic [TICK_W-1:0] high_len_q;

	logic [SLOT_W-1:0] slot_inc;
	logic [SLOT_W-1:0] slot_nxt;
	logic [TICK_W-1:0] h_raw;
	logic [TICK_W-1:0] h_clip;
	logic [TICK_W-1:0] h_len;
	logic              low_ok;
	logic [TICK_W-1:0] tl_pre;
	logic [SLOT_W-1:0] slot_d;
	logic              phase_d;
	logic [TICK_W-1:0] ticks_d;
	logic [TICK_W-1:0] high_d;
	logic [SLOT_W-1:0] slot_r;
	logic              phase_r;

	assign slot_inc = slot_q + 1'b1;
	assign slot_nxt = ({1'b0, slot_inc} >= (SLOT_W+1)'(CHANNELS)) ? '0 : slot_inc;

	// End of a high phase reads the next channel's width.
	assign rd_idx = (ticks_left_q == '0 && phase_high_q) ? slot_nxt : slot_q;

	assign h_raw  = {rd_data, 1'b0};
	assign h_clip = (h_raw > slot_ticks) ? slot_ticks : h_raw;
	assign h_len  = (h_clip == '0) ? TICK_W'(1) : h_clip;
	assign low_ok = slot_ticks > high_len_q;

	always_comb begin
		slot_d  = slot_q;
		phase_d = phase_high_q;
		high_d  = high_len_q;
		tl_pre  = ticks_left_q;
		if (ticks_left_q == '0) begin
			if (!phase_high_q) begin
				phase_d = 1'b1;
				high_d  = h_len;
				tl_pre  = h_len;
			end else begin
				slot_d = slot_nxt;
				if (low_ok) begin
					phase_d = 1'b0;
					tl_pre  = slot_ticks - high_len_q;
				end else begin
					phase_d = 1'b1;
					high_d  = h_len;
					tl_pre  = h_len;
				end
			end
		end
		ticks_d = tl_pre - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q       <= '0;
			phase_high_q <= 1'b0;
			ticks_left_q <= '0;
			high_len_q   <= '0;
		end else if (tick) begin
			slot_q       <= slot_d;
			phase_high_q <= phase_d;
			ticks_left_q <= ticks_d;
			high_len_q   <= high_d;
		end
	end

	// Result shows the state after the item.
	assign slot_r  = tick ? slot_d : slot_q;
	assign phase_r = tick ? phase_d : phase_high_q;

	always_comb begin
		res.slot = slot_r;
		for (int n = 0; n < PIN_W; n++) begin
			res.pins[n] = (phase_r && slot_r == SLOT_W'(n)) ? active_level : ~active_level;
		end
	end

endmodule

// ===== hw/rtl/servo_pulse_sequencer_unit.sv =====
// An item accepted into stage 1 shows its result on m_tvalid once stage 2
// has registered it, which waits while m_tready stalls the output.
// Throughput: one item per cycle unless m_tready stalls; stage 1 registers the
// item, then the slot timer and pulse table update and stage 2 registers the result.
// Reset (arst_n low, asynchronous): slot 0, low phase with zero ticks left,
// trim default widths, slot_ticks 5000, active_level 1, pipeline empty.
module servo_pulse_sequencer_unit #(
	parameter int CHANNELS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [svps_pkg::DATA_W-1:0]  s_tdata,  // channel[3:0], width[15:4]
	input  logic                         s_tuser,  // kind[0]
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [svps_pkg::DATA_W-1:0]  m_tdata,  // pins[11:0], current_slot[15:12]
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_index,
	input  logic [svps_pkg::TICK_W-1:0]  cfg_data
);
	import svps_pkg::*;

	logic                valid_s1;
	logic                kind_s1;
	logic [SLOT_W-1:0]   chan_s1;
	logic [WIDTH_W-1:0]  width_s1;
	logic                go_s1;
	logic [TICK_W-1:0]   slot_ticks_q;
	logic                active_level_q;
	tbl_wr_t             tbl_wr;
	logic [SLOT_W-1:0]   rd_idx;
	logic [WIDTH_W-1:0]  rd_data;
	result_t             res;
	result_t             res_s2;
	logic                valid_s2;

	assign go_s1    = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || go_s1;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1  <= s_tuser;
			chan_s1  <= s_tdata[SLOT_W-1:0];
			width_s1 <= s_tdata[SLOT_W +: WIDTH_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_ticks_q   <= SLOT_TICKS_RESET;
			active_level_q <= ACTIVE_LEVEL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_SLOT_TICKS:   slot_ticks_q   <= cfg_data;
				CFG_ACTIVE_LEVEL: active_level_q <= cfg_data[0];
				default:          slot_ticks_q   <= slot_ticks_q;
			endcase
		end
	end

	always_comb begin
		tbl_wr.en   = go_s1 && kind_s1 == KIND_WRITE
			&& {1'b0, chan_s1} < (SLOT_W+1)'(CHANNELS);
		tbl_wr.addr = chan_s1;
		tbl_wr.data = width_s1;
	end

	svps_table #(
		.CHANNELS(CHANNELS)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (tbl_wr),
		.rd_idx (rd_idx),
		.rd_data(rd_data)
	);

	svps_seq #(
		.CHANNELS(CHANNELS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick        (go_s1 && kind_s1 == KIND_TICK),
		.slot_ticks  (slot_ticks_q),
		.active_level(active_level_q),
		.rd_data     (rd_data),
		.rd_idx      (rd_idx),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.slot, res_s2.pins};

endmodule

// ===== hw/rtl/svps_checker.sv =====
`include "servo_pulse_sequencer_unit_macros.svh"

module svps_checker #(
	parameter int CHANNELS = 12
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [svps_pkg::DATA_W-1:0]  m_tdata
);
	import svps_pkg::*;

	// A stalled item holds.
	`SVPS_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

	`SVPS_ASSERT_ALWAYS(a_slot_range, m_tvalid |-> {1'b0, m_tdata[15:12]} < 5'(CHANNELS), "slot out of range")

	// At most one pin differs from the idle level.
	`SVPS_ASSERT(a_one_pin, m_tvalid |-> ($countones(m_tdata[11:0]) <= 1 || $countones(~m_tdata[11:0]) <= 1), "more than one pin active")

	// With the result side free, input is never refused.
	`SVPS_ASSERT(a_no_stall, !m_tvalid && $past(!m_tvalid) |-> s_tready, "input stalled with free output")

endmodule

bind servo_pulse_sequencer_unit svps_checker #(
	.CHANNELS(CHANNELS)
) u_svps_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
